// ===== rtl/fccq_pkg.sv =====
package fccq_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W     = $clog2(CHANNELS + 1);

    localparam int KIND_W    = 2;
    localparam int VAL_W     = 8;
    localparam int LVL_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_CH_W  = 3;
    localparam int PROD_W    = 33;
    localparam int STEP_W    = 5;

    localparam logic [VAL_W-1:0] RESET_BYTE = 8'd254;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;

    // result kinds
    localparam logic RES_EVENT = 1'b0;
    localparam logic RES_FADE  = 1'b1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICKER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF   = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_ACCEPT  = 4'd1,
        OP_COMMIT  = 4'd2,
        OP_ARM     = 4'd3,
        OP_ADVANCE = 4'd4,
        OP_PTR_CLR = 4'd5,
        OP_TICK    = 4'd6,
        OP_IDX_CLR = 4'd7,
        OP_MUL     = 4'd8,
        OP_FADE    = 4'd9,
        OP_IDX_INC = 4'd10
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER       = 4'd0,
        C_ALWAYS      = 4'd1,
        C_NO_INPUT    = 4'd2,
        C_KIND_TICK   = 4'd3,
        C_KIND_FRAME  = 4'd4,
        C_NOT_BYTE    = 4'd5,
        C_RESET_BYTE  = 4'd6,
        C_PTR_FULL    = 4'd7,
        C_NO_CHANGE   = 4'd8,
        C_NOT_PENDING = 4'd9,
        C_TOO_YOUNG   = 4'd10,
        C_OUT_BUSY    = 4'd11,
        C_IDX_LAST    = 4'd12
    } cond_t;

    // one microcode word
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic              gate;    // op runs only when the jump is not taken
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic op_en;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic kind_tick;
        logic kind_frame;
        logic not_byte;
        logic reset_byte;
        logic ptr_full;
        logic no_change;
        logic not_pending;
        logic too_young;
        logic out_busy;
        logic idx_last;
    } status_t;

endpackage

// ===== rtl/fccq_seq.sv =====
module fccq_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  fccq_pkg::status_t status,
    output fccq_pkg::ctrl_t   ctrl,
    output logic              in_ready
);
    import fccq_pkg::*;

    localparam logic [STEP_W-1:0] S_FETCH    = 5'd0;
    localparam logic [STEP_W-1:0] S_ADVANCE  = 5'd10;
    localparam logic [STEP_W-1:0] S_ARM      = 5'd11;
    localparam logic [STEP_W-1:0] S_PTR_CLR  = 5'd12;
    localparam logic [STEP_W-1:0] S_TICK     = 5'd13;
    localparam logic [STEP_W-1:0] S_FRAME    = 5'd14;
    localparam logic [STEP_W-1:0] S_MUL      = 5'd15;
    localparam logic [STEP_W-1:0] S_FADE     = 5'd16;
    localparam logic [STEP_W-1:0] S_COMMIT   = 5'd9;

    function automatic uword_t rom(input logic [STEP_W-1:0] s);
        uword_t w;
        case (s)
            5'd0:  w = '{op: OP_ACCEPT,  cond: C_NO_INPUT,    gate: 1'b1, target: S_FETCH};
            5'd1:  w = '{op: OP_NOP,     cond: C_KIND_TICK,   gate: 1'b0, target: S_TICK};
            5'd2:  w = '{op: OP_NOP,     cond: C_KIND_FRAME,  gate: 1'b0, target: S_FRAME};
            5'd3:  w = '{op: OP_NOP,     cond: C_NOT_BYTE,    gate: 1'b0, target: S_FETCH};
            5'd4:  w = '{op: OP_NOP,     cond: C_RESET_BYTE,  gate: 1'b0, target: S_PTR_CLR};
            5'd5:  w = '{op: OP_NOP,     cond: C_PTR_FULL,    gate: 1'b0, target: S_FETCH};
            5'd6:  w = '{op: OP_NOP,     cond: C_NO_CHANGE,   gate: 1'b0, target: S_ADVANCE};
            5'd7:  w = '{op: OP_NOP,     cond: C_NOT_PENDING, gate: 1'b0, target: S_ARM};
            5'd8:  w = '{op: OP_NOP,     cond: C_TOO_YOUNG,   gate: 1'b0, target: S_ADVANCE};
            5'd9:  w = '{op: OP_COMMIT,  cond: C_OUT_BUSY,    gate: 1'b1, target: S_COMMIT};
            5'd10: w = '{op: OP_ADVANCE, cond: C_ALWAYS,      gate: 1'b0, target: S_FETCH};
            5'd11: w = '{op: OP_ARM,     cond: C_ALWAYS,      gate: 1'b0, target: S_ADVANCE};
            5'd12: w = '{op: OP_PTR_CLR, cond: C_ALWAYS,      gate: 1'b0, target: S_FETCH};
            5'd13: w = '{op: OP_TICK,    cond: C_ALWAYS,      gate: 1'b0, target: S_FETCH};
            5'd14: w = '{op: OP_IDX_CLR, cond: C_NEVER,       gate: 1'b0, target: S_FETCH};
            5'd15: w = '{op: OP_MUL,     cond: C_NEVER,       gate: 1'b0, target: S_FETCH};
            5'd16: w = '{op: OP_FADE,    cond: C_OUT_BUSY,    gate: 1'b1, target: S_FADE};
            5'd17: w = '{op: OP_IDX_INC, cond: C_IDX_LAST,    gate: 1'b1, target: S_FETCH};
            5'd18: w = '{op: OP_NOP,     cond: C_ALWAYS,      gate: 1'b0, target: S_MUL};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,      gate: 1'b0, target: S_FETCH};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            uw;
    logic              jump;

    assign uw = rom(step_reg);

    always_comb begin
        case (uw.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_INPUT:    jump = status.no_input;
            C_KIND_TICK:   jump = status.kind_tick;
            C_KIND_FRAME:  jump = status.kind_frame;
            C_NOT_BYTE:    jump = status.not_byte;
            C_RESET_BYTE:  jump = status.reset_byte;
            C_PTR_FULL:    jump = status.ptr_full;
            C_NO_CHANGE:   jump = status.no_change;
            C_NOT_PENDING: jump = status.not_pending;
            C_TOO_YOUNG:   jump = status.too_young;
            C_OUT_BUSY:    jump = status.out_busy;
            C_IDX_LAST:    jump = status.idx_last;
            default:       jump = 1'b1;
        endcase
    end

    assign step_next  = jump ? uw.target : step_reg + 5'd1;
    assign ctrl.op    = uw.op;
    assign ctrl.op_en = !(uw.gate && jump);
    assign in_ready   = (step_reg == S_FETCH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/fccq_dp.sv =====
module fccq_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fccq_pkg::ctrl_t                 ctrl,
    output fccq_pkg::status_t               status,
    input  logic                            in_valid,
    input  logic [fccq_pkg::KIND_W-1:0]     in_kind,
    input  logic [fccq_pkg::VAL_W-1:0]      in_byte,
    input  logic                            cfg_wr_en,
    input  logic [fccq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fccq_pkg::CFG_W-1:0]      cfg_wr_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_kind,
    output logic [fccq_pkg::OUT_CH_W-1:0]   out_channel,
    output logic [fccq_pkg::VAL_W-1:0]      out_value,
    output logic [fccq_pkg::LVL_W-1:0]      out_level,
    output logic                            out_last
);
    import fccq_pkg::*;

    logic [CFG_W-1:0]  filter_reg, flicker_reg, coeff_reg;
    logic [TIME_W-1:0] time_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [CH_W-1:0]   idx_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [VAL_W-1:0]  byte_reg;

    logic [VAL_W-1:0]  val_reg  [CHANNELS];
    logic [TIME_W-1:0] lct_reg  [CHANNELS];
    logic [TIME_W-1:0] ps_reg   [CHANNELS];
    logic              pend_reg [CHANNELS];
    logic [LVL_W-1:0]  lvl_reg  [CHANNELS];

    logic [PROD_W-1:0] prod_reg;

    logic              m_valid_reg;
    logic              m_kind_reg;
    logic [OUT_CH_W-1:0] m_ch_reg;
    logic [VAL_W-1:0]  m_val_reg;
    logic [LVL_W-1:0]  m_lvl_reg;
    logic              m_last_reg;

    logic [CH_W-1:0]   p;
    logic [TIME_W-1:0] since_change, since_arm;
    logic              active;
    logic [16:0]       factor;
    logic [PROD_W-1:0] rounded;
    logic [16:0]       scaled;
    logic [17:0]       rise_sum;
    logic [LVL_W-1:0]  lvl_new;
    logic              run;
    logic              load;

    assign p            = ptr_reg[CH_W-1:0];
    assign since_change = time_reg - lct_reg[p];
    assign since_arm    = time_reg - ps_reg[p];

    assign status.no_input    = !in_valid;
    assign status.kind_tick   = (kind_reg == KIND_TICK);
    assign status.kind_frame  = (kind_reg == KIND_FRAME);
    assign status.not_byte    = (kind_reg != KIND_BYTE);
    assign status.reset_byte  = (byte_reg == RESET_BYTE);
    assign status.ptr_full    = (ptr_reg >= PTR_W'(CHANNELS));
    assign status.no_change   = !((val_reg[p] != byte_reg)
                                  && (since_change > TIME_W'(filter_reg)));
    assign status.not_pending = !pend_reg[p];
    assign status.too_young   = !(since_arm > TIME_W'(flicker_reg));
    assign status.out_busy    = m_valid_reg && !out_ready;
    assign status.idx_last    = (idx_reg == CH_W'(CHANNELS - 1));

    // fade: active level becomes c + (1-c)*l (saturated), inactive becomes c*l, Q0.16 rounded
    assign active   = (val_reg[idx_reg] != '0);
    assign factor   = active ? (17'h10000 - {1'b0, coeff_reg}) : {1'b0, coeff_reg};
    assign rounded  = prod_reg + PROD_W'(32768);
    assign scaled   = rounded[32:16];
    assign rise_sum = {2'b00, coeff_reg} + {1'b0, scaled};
    always_comb begin
        if (active) begin
            lvl_new = (rise_sum > 18'd65535) ? 16'hFFFF : rise_sum[15:0];
        end else begin
            lvl_new = scaled[15:0];
        end
    end

    assign run  = ctrl.op_en;
    assign load = run && (ctrl.op == OP_COMMIT || ctrl.op == OP_FADE);

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg  <= 16'd100;
            flicker_reg <= 16'd100;
            coeff_reg   <= 16'd58982;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FILTER:  filter_reg  <= cfg_wr_data;
                CFG_FLICKER: flicker_reg <= cfg_wr_data;
                CFG_COEFF:   coeff_reg   <= cfg_wr_data;
                default:     ;
            endcase
        end
    end

    // control and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            ptr_reg  <= '0;
            idx_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                val_reg[i]  <= '0;
                lct_reg[i]  <= '0;
                ps_reg[i]   <= '0;
                pend_reg[i] <= 1'b0;
                lvl_reg[i]  <= '0;
            end
        end else if (run) begin
            case (ctrl.op)
                OP_COMMIT: begin
                    pend_reg[p] <= 1'b0;
                    val_reg[p]  <= byte_reg;
                    lct_reg[p]  <= time_reg;
                end
                OP_ARM: begin
                    pend_reg[p] <= 1'b1;
                    ps_reg[p]   <= time_reg;
                end
                OP_ADVANCE: ptr_reg  <= ptr_reg + PTR_W'(1);
                OP_PTR_CLR: ptr_reg  <= '0;
                OP_TICK:    time_reg <= time_reg + TIME_W'(1);
                OP_IDX_CLR: idx_reg  <= '0;
                OP_IDX_INC: idx_reg  <= idx_reg + CH_W'(1);
                OP_FADE:    lvl_reg[idx_reg] <= lvl_new;
                default:    ;
            endcase
        end
    end

    // item latch and product register
    always_ff @(posedge aclk) begin
        if (run && ctrl.op == OP_ACCEPT) begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
        end
        if (run && ctrl.op == OP_MUL) begin
            prod_reg <= PROD_W'(factor) * PROD_W'(lvl_reg[idx_reg]);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (ctrl.op == OP_COMMIT) begin
                m_kind_reg <= RES_EVENT;
                m_ch_reg   <= OUT_CH_W'(p);
                m_val_reg  <= byte_reg;
                m_lvl_reg  <= lvl_reg[p];
                m_last_reg <= 1'b1;
            end else begin
                m_kind_reg <= RES_FADE;
                m_ch_reg   <= OUT_CH_W'(idx_reg);
                m_val_reg  <= val_reg[idx_reg];
                m_lvl_reg  <= lvl_new;
                m_last_reg <= status.idx_last;
            end
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_kind    = m_kind_reg;
    assign out_channel = m_ch_reg;
    assign out_value   = m_val_reg;
    assign out_level   = m_lvl_reg;
    assign out_last    = m_last_reg;

endmodule

// ===== rtl/framed_channel_change_qualifier.sv =====
// Framed channel change qualifier. Input items are serial bytes, time ticks
// and frame ticks (kind on s_tuser). Byte 254 rewinds the channel pointer;
// other bytes go to the channel under the pointer, which then advances and
// sticks once it passes the last channel. A differing byte more than the
// filter period after the channel's last change arms a pending mark; a
// later differing byte more than the flicker period after arming commits the
// value and emits one change event (result kind 0). A frame tick steps every
// channel's Q0.16 fade level toward full (channel nonzero) or toward zero and
// reports each level (result kind 1), tlast on the last channel.
// Control runs from a small microcode ROM: one step per cycle, with one
// 17x16 multiply per channel on a frame tick. An item is taken only at the
// fetch step, so a new item waits until the last one has run all its steps.
// The output register holds one result, so a stalled m_tready holds the
// sequencer only at the steps that emit a result.
module framed_channel_change_qualifier (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic [1:0]  s_tuser,    // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [2:0] channel, [10:3] new_value, [26:11] fade_level
    output logic [0:0]  m_tuser,    // [0] result_kind
    output logic        m_tlast,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,  // 0 filter period, 1 flicker period, 2 fade coefficient
    input  logic [15:0] cfg_wr_data
);
    import fccq_pkg::*;

    ctrl_t               ctrl;
    status_t             status;
    logic                res_kind;
    logic [OUT_CH_W-1:0] res_channel;
    logic [VAL_W-1:0]    res_value;
    logic [LVL_W-1:0]    res_level;

    fccq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    fccq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (s_tvalid),
        .in_kind     (s_tuser),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (res_kind),
        .out_channel (res_channel),
        .out_value   (res_value),
        .out_level   (res_level),
        .out_last    (m_tlast)
    );

    // pack result fields, lowest field first, zero fill to 32 bits
    assign m_tdata    = {5'd0, res_level, res_value, res_channel};
    assign m_tuser[0] = res_kind;

endmodule

// ===== tb/tb.sv =====
module tb;
    import fccq_pkg::*;

    // kind 3 is not decoded by the block; it must pass through with no effect
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 400;
    // longest item is a frame tick, which runs steps for every channel; plus margin
    localparam int unsigned DRAIN_GAP   = 24;

    typedef struct packed {
        bit        rkind;
        bit [2:0]  chan;
        bit [7:0]  val;
        bit [15:0] fade;
        bit        fin;
    } report_t;

    // Predicts change events and fade reports, queues them in arrival order
    // and checks what the block puts out against the oldest one.
    class channel_report_board;
        bit [15:0] filter_ticks;
        bit [15:0] flicker_ticks;
        bit [15:0] coeff;
        bit [31:0] ticks_now;
        bit [3:0]  ptr;
        bit [7:0]  value      [CHANNELS];
        bit [31:0] changed_at [CHANNELS];
        bit [31:0] armed_at   [CHANNELS];
        bit        armed      [CHANNELS];
        bit [15:0] lvl        [CHANNELS];
        report_t   expected_reports[$];
        int        useful;
        int        errors;

        function new();
            filter_ticks  = 16'd100;
            flicker_ticks = 16'd100;
            coeff         = 16'd58982;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] v);
            case (idx)
                CFG_FILTER:  filter_ticks  = v;
                CFG_FLICKER: flicker_ticks = v;
                CFG_COEFF:   coeff         = v;
                default: ;
            endcase
        endfunction

        // one Q0.16 fade step, rounded; the rise saturates at full scale
        function bit [15:0] step_fade(bit [15:0] l, bit up);
            bit [33:0] prod;
            bit [33:0] sum;
            if (up) begin
                prod = (34'd65536 - {18'd0, coeff}) * {18'd0, l} + 34'd32768;
                sum  = {18'd0, coeff} + {16'd0, prod[33:16]};
                return (sum > 34'd65535) ? 16'hFFFF : sum[15:0];
            end
            prod = {18'd0, coeff} * {18'd0, l} + 34'd32768;
            return prod[31:16];
        endfunction

        function void take_item(bit [1:0] kind, bit [7:0] data);
            report_t r;
            int      p;
            case (kind)
                KIND_TICK: begin
                    ticks_now = ticks_now + 32'd1;
                    useful++;
                end
                KIND_FRAME: begin
                    useful++;
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        lvl[ch] = step_fade(lvl[ch], value[ch] != 8'd0);
                        r.rkind = RES_FADE;
                        r.chan  = 3'(ch);
                        r.val   = value[ch];
                        r.fade  = lvl[ch];
                        r.fin   = (ch == CHANNELS - 1);
                        expected_reports.push_back(r);
                    end
                end
                KIND_BYTE: begin
                    if (data == RESET_BYTE) begin
                        ptr = 4'd0;
                        useful++;
                    end else if (ptr < CHANNELS) begin
                        useful++;
                        p = int'(ptr);
                        if (value[p] != data && (ticks_now - changed_at[p]) > filter_ticks) begin
                            if (!armed[p]) begin
                                armed[p]    = 1'b1;
                                armed_at[p] = ticks_now;
                            end else if ((ticks_now - armed_at[p]) > flicker_ticks) begin
                                armed[p]      = 1'b0;
                                value[p]      = data;
                                changed_at[p] = ticks_now;
                                r.rkind = RES_EVENT;
                                r.chan  = 3'(p);
                                r.val   = data;
                                r.fade  = lvl[p];
                                r.fin   = 1'b1;
                                expected_reports.push_back(r);
                            end
                        end
                        ptr = ptr + 4'd1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_report(logic rkind, logic [2:0] chan, logic [7:0] val,
                                   logic [15:0] fade, logic fin);
            report_t want;
            if (expected_reports.size() == 0) begin
                $error("unexpected result: result_kind %0d channel %0d", rkind, chan);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (rkind !== want.rkind) begin
                $error("result_kind: expected %0d, got %0d", want.rkind, rkind);
                errors++;
            end
            if (chan !== want.chan) begin
                $error("channel: expected %0d, got %0d", want.chan, chan);
                errors++;
            end
            if (val !== want.val) begin
                $error("new_value: expected %0d, got %0d", want.val, val);
                errors++;
            end
            if (fade !== want.fade) begin
                $error("fade_level: expected %0d, got %0d", want.fade, fade);
                errors++;
            end
            if (fin !== want.fin) begin
                $error("last: expected %0d, got %0d", want.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic [1:0]  s_tuser     = KIND_BYTE;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = CFG_FILTER;
    logic [15:0] cfg_wr_data = 16'd0;

    channel_report_board board;

    int unsigned send_idle = 0;   // percent of cycles the sender holds back
    int unsigned take_idle = 0;   // percent of cycles the receiver holds back
    int unsigned hold_reqs = 0;   // bumped by the main flow to ask for a long stall
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned cycles    = 0;

    framed_channel_change_qualifier DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // watchdog: a hung handshake or a lost result ends up here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random backpressure, or a long solid stall when asked for.
    // hold_reqs is written with <= at the falling edge, so this block sees a
    // new request at the next falling edge, never in the same step.
    always @(negedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= take_idle);
        end
    end

    // results are taken at the rising edge, from values settled before it
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_report(m_tuser[0], m_tdata[2:0], m_tdata[10:3], m_tdata[26:11],
                               m_tlast);
    end

    task automatic set_idle(int unsigned sender, int unsigned receiver);
        send_idle = sender;
        take_idle <= receiver;
    endtask

    // Called at a falling edge, returns at the falling edge after the accept.
    // s_tvalid is left high so back-to-back items need no drop in between.
    task automatic send_item(bit [1:0] kind, bit [7:0] data);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        board.take_item(kind, data);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every predicted result, then give the block
    // time to finish items that produce nothing (ticks, dropped bytes).
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.expected_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    // all three registers, one per cycle; only called with the block idle
    task automatic configure(bit [15:0] filt, bit [15:0] flick, bit [15:0] coef);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_FILTER;
        cfg_wr_data <= filt;
        board.set_reg(CFG_FILTER, filt);
        @(negedge aclk);
        cfg_index   <= CFG_FLICKER;
        cfg_wr_data <= flick;
        board.set_reg(CFG_FLICKER, flick);
        @(negedge aclk);
        cfg_index   <= CFG_COEFF;
        cfg_wr_data <= coef;
        board.set_reg(CFG_COEFF, coef);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hand-picked opening, run with filter 0, flicker 0, full-scale coeff.
    task automatic opening_items();
        send_item(KIND_SPARE, 8'hFF);          // undecoded kind
        send_item(KIND_FRAME, 8'hA5);          // all channels idle, junk data
        send_item(KIND_TICK,  8'hFF);          // junk data on a tick
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'hFF);          // ch0 arms
        send_item(KIND_BYTE,  8'h00);          // ch1 equal byte
        send_item(KIND_BYTE,  8'h01);          // ch2 arms
        send_item(KIND_BYTE,  8'h80);          // ch3 arms
        send_item(KIND_BYTE,  8'h55);          // pointer past the end: dropped
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'h7F);          // ch0 armed this very tick: too young
        send_item(KIND_TICK,  8'h00);
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'h7F);          // ch0 commits, start event
        send_item(KIND_BYTE,  8'h00);          // ch1 equal, its mark untouched
        send_item(KIND_BYTE,  8'hAA);          // ch2 commits
        send_item(KIND_BYTE,  8'h80);          // ch3 commits
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'h33);          // ch0 too soon after its change
        send_item(KIND_FRAME, 8'h5A);          // active channels jump to full scale
        send_item(KIND_TICK,  8'h00);
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'h00);          // ch0 arms toward stop
        send_item(KIND_TICK,  8'h00);
        send_item(KIND_BYTE,  RESET_BYTE);
        send_item(KIND_BYTE,  8'h00);          // ch0 commits, stop event
        send_item(KIND_FRAME, 8'h00);          // rise saturates at full scale
    endtask

    // Mostly zero or the channel's own value, so arms, drops and commits
    // all turn up; 254 is kept out of well-formed sweeps.
    function automatic bit [7:0] pick_byte(int ch);
        int unsigned r;
        bit [7:0]    b;
        r = $urandom_range(99);
        if (r < 35)
            return 8'd0;
        if (r < 55)
            return board.value[ch];
        b = 8'($urandom);
        return (b == RESET_BYTE) ? 8'd0 : b;
    endfunction

    // One pass over the channels: rewind, then a byte per channel with a few
    // ticks between, at times a frame tick at the end; sometimes cut short.
    task automatic send_sweep();
        int stop_at;
        stop_at = ($urandom_range(9) == 0) ? int'($urandom_range(CHANNELS - 1)) : CHANNELS;
        send_item(KIND_BYTE, RESET_BYTE);
        for (int ch = 0; ch < stop_at; ch++) begin
            repeat ($urandom_range(3)) send_item(KIND_TICK, 8'($urandom));
            send_item(KIND_BYTE, pick_byte(ch));
        end
        if ($urandom_range(9) < 3)
            send_item(KIND_FRAME, 8'($urandom));
    endtask

    // n items that the block acts on; undecoded kinds and bytes past the
    // last channel come on top
    task automatic random_run(int n);
        int          target;
        int unsigned r;
        target = board.useful + n;
        while (board.useful < target) begin
            r = $urandom_range(99);
            if (r < 8)
                send_item(KIND_SPARE, 8'($urandom));
            else if (r < 14)
                send_item(KIND_BYTE, 8'($urandom));    // stray byte, any value
            else if (r < 18)
                send_item(KIND_TICK, 8'($urandom));
            else if (r < 22)
                send_item(KIND_FRAME, 8'($urandom));
            else
                send_sweep();
        end
    endtask

    initial begin
        board = new();
        wait (aresetn === 1'b1);
        @(negedge aclk);

        // slow receiver, mostly eager sender
        set_idle(15, 72);
        configure(16'd0, 16'd0, 16'hFFFF);
        opening_items();
        settle();

        configure(16'd2, 16'd3, 16'd58982);
        random_run(70);
        // long receiver stall while frame ticks keep coming: the output
        // register fills and the block has to hold off its input
        hold_reqs <= hold_reqs + 1;
        repeat (6) send_item(KIND_FRAME, 8'($urandom));
        random_run(30);
        settle();                              // sender waits for a full drain
        random_run(40);
        settle();

        // slow sender, mostly eager receiver
        set_idle(72, 15);
        configure(16'hFFFF, 16'hFFFF, 16'd0);  // nothing can arm; idle levels drop to zero
        random_run(35);
        settle();
        configure(16'd1, 16'd4, 16'd40000);
        random_run(85);
        settle();

        // no idling on either side
        set_idle(0, 0);
        configure(16'd3, 16'd0, 16'd32768);
        random_run(85);
        settle();

        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== framed_channel_change_qualifier.f =====
rtl/fccq_pkg.sv
rtl/fccq_seq.sv
rtl/fccq_dp.sv
rtl/framed_channel_change_qualifier.sv
tb/tb.sv
